/* sv/tstc_pkg.sv */
// Shared types, codes and trigger compare function for the two-stage trigger
// capture controller. No dependencies.

package tstc_pkg;

    // Capture state as reported in the status field
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_RUNNING   = 3'd1,
        ST_TRIGGERED = 3'd2,
        ST_DONE      = 3'd3,
        ST_ERROR     = 3'd4
    } run_state_t;

    // Command carried with each input word
    typedef enum logic [1:0] {
        FN_TICK       = 2'd0,
        FN_START_TRIG = 2'd1,
        FN_START_POLL = 2'd2,
        FN_CLEAR      = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TRIG_A   = 3'd0,
        REG_TRIG_B   = 3'd1,
        REG_PRE      = 3'd2,
        REG_POST     = 3'd3,
        REG_DIVIDE   = 3'd4,
        REG_TIMEOUT  = 3'd5,
        REG_CHANNELS = 3'd6,
        REG_SPARE    = 3'd7
    } reg_idx_t;

    // Trigger operation codes
    localparam logic [3:0] OP_GT    = 4'd0;
    localparam logic [3:0] OP_GE    = 4'd1;
    localparam logic [3:0] OP_LT    = 4'd2;
    localparam logic [3:0] OP_LE    = 4'd3;
    localparam logic [3:0] OP_NE    = 4'd4;
    localparam logic [3:0] OP_EQ    = 4'd5;
    localparam logic [3:0] OP_IMM   = 4'd6;
    localparam logic [3:0] OP_F_GT  = 4'd7;
    localparam logic [3:0] OP_F_GE  = 4'd8;
    localparam logic [3:0] OP_F_LT  = 4'd9;
    localparam logic [3:0] OP_F_LE  = 4'd10;
    localparam logic [3:0] OP_F_NE  = 4'd11;
    localparam logic [3:0] OP_F_EQ  = 4'd12;

    localparam int          SETUP_W      = 36;
    localparam logic [2:0]  MAX_CHANNELS = 3'd6;

    // One result word
    typedef struct packed {
        logic       trigger_hit;
        logic       write_head;
        logic       capture;
        logic       sampled;
        run_state_t status;
    } out_word_t;

    // Map float32 bits to an unsigned key with the same ordering (+0 == -0)
    function automatic logic [31:0] order_key(input logic [31:0] b);
        logic [31:0] z;
        begin
            z = (b[30:0] == 31'd0) ? 32'd0 : b;
            order_key = z[31] ? ~z : (z | 32'h8000_0000);
        end
    endfunction

    function automatic logic is_nan32(input logic [31:0] b);
        is_nan32 = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Evaluate one trigger condition; pre_zero tells whether the pre-count ran out
    function automatic logic trig_cond(input logic [SETUP_W-1:0] setup,
                                       input logic [31:0] sig,
                                       input logic pre_zero);
        logic [3:0]         op;
        logic signed [15:0] v;
        logic signed [15:0] l;
        logic [31:0]        lb;
        logic [31:0]        ka;
        logic [31:0]        kb;
        logic               nan;
        logic               res;
        begin
            op  = setup[35:32];
            v   = signed'(sig[15:0] & setup[31:16]);
            l   = signed'(setup[15:0]);
            lb  = {setup[15:0], 16'd0};
            ka  = order_key(sig);
            kb  = order_key(lb);
            nan = is_nan32(sig) || is_nan32(lb);
            unique case (op)
                OP_GT:   res = v > l;
                OP_GE:   res = v >= l;
                OP_LT:   res = v < l;
                OP_LE:   res = v <= l;
                OP_NE:   res = v != l;
                OP_EQ:   res = v == l;
                OP_IMM:  res = pre_zero;
                OP_F_GT: res = !nan && (ka > kb);
                OP_F_GE: res = !nan && (ka >= kb);
                OP_F_LT: res = !nan && (ka < kb);
                OP_F_LE: res = !nan && (ka <= kb);
                OP_F_NE: res = nan || (ka != kb);
                OP_F_EQ: res = !nan && (ka == kb);
                default: res = 1'b0;
            endcase
            trig_cond = res;
        end
    endfunction

endpackage

/* sv/two_stage_trigger_capture_controller.sv */
// Two-stage trigger capture controller: top level with input register,
// state update and result register. Depends on tstc_pkg.
//
// Usage: each word on the s_ side carries a command in s_tuser (tick, start
// triggered capture, start auto poll, clear) and the watched words plus the
// timeout and FIFO-reject flags in s_tdata. Every accepted word yields exactly
// one result word on the m_ side: the capture state after that word, and the
// sampled, capture, write_head and trigger_hit strobes.
// Path: an accepted word is held in the input register; its result is then
// loaded into the result register once that is free, and offered on m_tvalid
// from then on.
// Throughput: one word per cycle while m_tready is high; the state update for one word
// is a single pass of compares and counter steps between the two registers.
// Stall: while m_tready is low the result waits in the result register, one
// more word may sit in the input register, and s_tready drops after that.
// Reset: all configuration registers and state clear to zero (idle), both
// register stages empty. Configuration is written over the APB port with
// registers at byte address 8*index; writes are expected only while idle.

module two_stage_trigger_capture_controller
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [31:0] sig_a, [63:32] sig_b, [64] timeout_event,
                                   // [65] fifo_reject, [71:66] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] status, [3] sampled, [4] capture,
                                   // [5] write_head, [6] trigger_hit, [7] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [tstc_pkg::SETUP_W-1:0] trig_a_reg, trig_b_reg;
    logic [15:0] pre_count_reg, post_count_reg;
    logic [7:0]  sample_div_reg;
    logic        timeout_en_reg;
    logic [2:0]  act_chan_reg, act_chan_next;

    // state
    tstc_pkg::run_state_t run_state_reg, run_state_next;
    logic [1:0]  trig_stage_reg, trig_stage_next;
    logic [15:0] pre_left_reg, pre_left_next;
    logic [15:0] post_left_reg, post_left_next;
    logic [7:0]  rate_left_reg, rate_left_next;
    logic        auto_poll_reg, auto_poll_next;

    // input register
    logic                in_valid_reg;
    tstc_pkg::func_t     in_func_reg;
    logic [31:0]         in_sig_a_reg, in_sig_b_reg;
    logic                in_tmo_reg, in_rej_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    tstc_pkg::out_word_t  out_word_reg, out_word_next;

    logic        advance;
    logic        s_accept;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [2:0]  nch;
    logic        chan_any;
    logic        pre_zero;
    logic        a_fire, b_fire;
    logic        stage_one;
    logic [7:0]  rate_dec;

    // handshakes
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_word_reg};
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[5:3];

    // register read-back
    always_comb
    begin
        unique case (tstc_pkg::reg_idx_t'(cfg_idx))
            tstc_pkg::REG_TRIG_A:   prdata = {28'd0, trig_a_reg};
            tstc_pkg::REG_TRIG_B:   prdata = {28'd0, trig_b_reg};
            tstc_pkg::REG_PRE:      prdata = {48'd0, pre_count_reg};
            tstc_pkg::REG_POST:     prdata = {48'd0, post_count_reg};
            tstc_pkg::REG_DIVIDE:   prdata = {56'd0, sample_div_reg};
            tstc_pkg::REG_TIMEOUT:  prdata = {63'd0, timeout_en_reg};
            tstc_pkg::REG_CHANNELS: prdata = {61'd0, act_chan_reg};
            default:                prdata = 64'd0;
        endcase
    end

    // trigger compares; pre_left only counts down when an immediate condition does not fire
    assign nch       = (act_chan_reg > tstc_pkg::MAX_CHANNELS) ? tstc_pkg::MAX_CHANNELS
                                                                : act_chan_reg;
    assign chan_any  = nch != 3'd0;
    assign pre_zero  = pre_left_reg == 16'd0;
    assign a_fire    = tstc_pkg::trig_cond(trig_a_reg, in_sig_a_reg, pre_zero);
    assign b_fire    = tstc_pkg::trig_cond(trig_b_reg, in_sig_b_reg, pre_zero);
    assign stage_one = (trig_stage_reg == 2'd1) || ((trig_stage_reg == 2'd0) && a_fire);
    assign rate_dec  = rate_left_reg - {7'd0, rate_left_reg != 8'd0};

    // state update for the word in the input register
    always_comb
    begin
        run_state_next  = run_state_reg;
        trig_stage_next = trig_stage_reg;
        pre_left_next   = pre_left_reg;
        post_left_next  = post_left_reg;
        rate_left_next  = rate_left_reg;
        auto_poll_next  = auto_poll_reg;
        act_chan_next   = act_chan_reg;
        out_word_next   = '{trigger_hit: 1'b0, write_head: 1'b0, capture: 1'b0,
                            sampled: 1'b0, status: run_state_reg};
        if (advance)
        begin
            unique case (in_func_reg)
                tstc_pkg::FN_START_TRIG:
                begin
                    pre_left_next   = pre_count_reg;
                    post_left_next  = post_count_reg;
                    trig_stage_next = 2'd0;
                    run_state_next  = tstc_pkg::ST_RUNNING;
                end
                tstc_pkg::FN_START_POLL:
                begin
                    auto_poll_next = 1'b1;
                    run_state_next = tstc_pkg::ST_RUNNING;
                end
                tstc_pkg::FN_CLEAR:
                begin
                    run_state_next = tstc_pkg::ST_IDLE;
                    auto_poll_next = 1'b0;
                    act_chan_next  = 3'd0;
                end
                default:
                begin
                    rate_left_next = rate_dec;
                    if (rate_dec == 8'd0)
                    begin
                        out_word_next.sampled = 1'b1;
                        rate_left_next = sample_div_reg;
                        if (run_state_reg == tstc_pkg::ST_RUNNING)
                        begin
                            if (timeout_en_reg && in_tmo_reg)
                            begin
                                run_state_next = tstc_pkg::ST_ERROR;
                            end
                            else if (!auto_poll_reg)
                            begin
                                if (trig_stage_reg == 2'd0 && !a_fire &&
                                    trig_a_reg[35:32] == tstc_pkg::OP_IMM)
                                begin
                                    pre_left_next = pre_left_reg - 16'd1;
                                end
                                else if (stage_one && !b_fire &&
                                         trig_b_reg[35:32] == tstc_pkg::OP_IMM)
                                begin
                                    pre_left_next = pre_left_reg - 16'd1;
                                end
                                if (stage_one && b_fire)
                                begin
                                    trig_stage_next           = 2'd2;
                                    out_word_next.trigger_hit = 1'b1;
                                    run_state_next            = tstc_pkg::ST_TRIGGERED;
                                end
                                else if (stage_one)
                                begin
                                    trig_stage_next = 2'd1;
                                end
                                out_word_next.capture = chan_any;
                            end
                            else if (chan_any)
                            begin
                                out_word_next.write_head = 1'b1;
                                out_word_next.capture    = 1'b1;
                            end
                        end
                        else if (run_state_reg == tstc_pkg::ST_TRIGGERED)
                        begin
                            if (timeout_en_reg && in_tmo_reg)
                            begin
                                run_state_next = tstc_pkg::ST_ERROR;
                            end
                            else if (post_left_reg == 16'd0)
                            begin
                                run_state_next = tstc_pkg::ST_DONE;
                            end
                            else
                            begin
                                if (chan_any)
                                begin
                                    out_word_next.capture = 1'b1;
                                    if (in_rej_reg)
                                    begin
                                        run_state_next = tstc_pkg::ST_ERROR;
                                    end
                                end
                                post_left_next = post_left_reg - 16'd1;
                            end
                        end
                    end
                end
            endcase
            out_word_next.status = run_state_next;
        end

        // configuration writes load counters and the channel count as a side effect
        if (cfg_wr)
        begin
            unique case (tstc_pkg::reg_idx_t'(cfg_idx))
                tstc_pkg::REG_PRE:      pre_left_next  = pwdata[15:0];
                tstc_pkg::REG_POST:     post_left_next = pwdata[15:0];
                tstc_pkg::REG_DIVIDE:   rate_left_next = 8'd0;
                tstc_pkg::REG_CHANNELS: act_chan_next  = pwdata[2:0];
                default:                ;
            endcase
        end
    end

    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_a_reg     <= '0;
            trig_b_reg     <= '0;
            pre_count_reg  <= '0;
            post_count_reg <= '0;
            sample_div_reg <= '0;
            timeout_en_reg <= 1'b0;
            act_chan_reg   <= '0;
            run_state_reg  <= tstc_pkg::ST_IDLE;
            trig_stage_reg <= '0;
            pre_left_reg   <= '0;
            post_left_reg  <= '0;
            rate_left_reg  <= '0;
            auto_poll_reg  <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (tstc_pkg::reg_idx_t'(cfg_idx))
                    tstc_pkg::REG_TRIG_A:  trig_a_reg     <= pwdata[tstc_pkg::SETUP_W-1:0];
                    tstc_pkg::REG_TRIG_B:  trig_b_reg     <= pwdata[tstc_pkg::SETUP_W-1:0];
                    tstc_pkg::REG_PRE:     pre_count_reg  <= pwdata[15:0];
                    tstc_pkg::REG_POST:    post_count_reg <= pwdata[15:0];
                    tstc_pkg::REG_DIVIDE:  sample_div_reg <= pwdata[7:0];
                    tstc_pkg::REG_TIMEOUT: timeout_en_reg <= pwdata[0];
                    default:               ;
                endcase
            end
            act_chan_reg   <= act_chan_next;
            run_state_reg  <= run_state_next;
            trig_stage_reg <= trig_stage_next;
            pre_left_reg   <= pre_left_next;
            post_left_reg  <= post_left_next;
            rate_left_reg  <= rate_left_next;
            auto_poll_reg  <= auto_poll_next;
            in_valid_reg   <= s_accept || (in_valid_reg && !advance);
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers: take a new word, hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg  <= tstc_pkg::func_t'(s_tuser);
            in_sig_a_reg <= s_tdata[31:0];
            in_sig_b_reg <= s_tdata[63:32];
            in_tmo_reg   <= s_tdata[64];
            in_rej_reg   <= s_tdata[65];
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // checks on the result word and the state update
    a_hit_means_triggered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.trigger_hit |->
            out_word_reg.status == tstc_pkg::ST_TRIGGERED && out_word_reg.sampled)
        else $error("trigger_hit without triggered status");

    a_capture_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.capture |-> out_word_reg.sampled)
        else $error("capture on a tick that was not a sample");

    a_head_with_capture: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.write_head |->
            out_word_reg.capture && out_word_reg.status == tstc_pkg::ST_RUNNING)
        else $error("write_head without capture while running");

    a_start_resets_stage: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_func_reg == tstc_pkg::FN_START_TRIG |=>
            trig_stage_reg == 2'd0 && run_state_reg == tstc_pkg::ST_RUNNING)
        else $error("start did not rearm the trigger");

    a_stage_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !$past(1'b0) && trig_stage_next == 2'd2 && trig_stage_reg != 2'd2 |->
            run_state_next == tstc_pkg::ST_TRIGGERED)
        else $error("trigger completed without entering triggered state");

endmodule
